// ----- rtl/core/rbc_pkg.sv -----
// Shared types, constants and digit helpers for the radix base converter.
`default_nettype none

package rbc_pkg;

    localparam int BASE_W      = 6;
    localparam int CHAR_W      = 8;
    localparam int STORE_DEPTH = 32;
    localparam int STORE_AW    = 5;
    localparam int CNT_W       = 6;
    localparam int FLAG_W      = 3;

    localparam logic [BASE_W-1:0] BASE_MIN      = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX      = 6'd36;
    localparam logic [BASE_W-1:0] IN_BASE_RST   = 6'd10;
    localparam logic [BASE_W-1:0] OUT_BASE_RST  = 6'd2;
    localparam logic [BASE_W-1:0] DIGIT_MAX_NUM = 6'd9;
    localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA    = 8'd55;
    localparam logic [CHAR_W-1:0] CHAR_LOWER    = 8'd87;

    // Configuration register indexes.
    typedef logic [0:0] cfg_addr_t;
    localparam cfg_addr_t REG_IN_BASE  = 1'b0;
    localparam cfg_addr_t REG_OUT_BASE = 1'b1;

    typedef struct packed {
        logic [BASE_W-1:0] digit;
        logic              bad;
    } char_dec_t;

    // Status of the shared divider.
    typedef struct packed {
        logic              done;
        logic [BASE_W-1:0] rem;
    } div_stat_t;

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        r = b;
        if (b < BASE_MIN) r = BASE_MIN;
        else if (b > BASE_MAX) r = BASE_MAX;
        return r;
    endfunction

    function automatic char_dec_t decode_char(input logic [CHAR_W-1:0] c);
        char_dec_t   d;
        logic [CHAR_W-1:0] t;
        d.bad = 1'b0;
        t     = '0;
        if (c >= "0" && c <= "9") t = c - CHAR_ZERO;
        else if (c >= "A" && c <= "Z") t = c - CHAR_ALPHA;
        else if (c >= "a" && c <= "z") t = c - CHAR_LOWER;
        else d.bad = 1'b1;
        d.digit = t[BASE_W-1:0];
        return d;
    endfunction

    function automatic logic [CHAR_W-1:0] encode_digit(input logic [BASE_W-1:0] r);
        logic [CHAR_W-1:0] w;
        w = {{(CHAR_W-BASE_W){1'b0}}, r};
        return (r > DIGIT_MAX_NUM) ? w + CHAR_ALPHA : w + CHAR_ZERO;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rbc_div.sv -----
// Shared restoring divider: one quotient bit per cycle by a small base.
`default_nettype none

module rbc_div #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [VALUE_BITS-1:0]         dividend,
    input  wire logic [rbc_pkg::BASE_W-1:0]    divisor,
    output logic [VALUE_BITS-1:0]              quotient,
    output rbc_pkg::div_stat_t                 stat
);
    import rbc_pkg::*;

    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(VALUE_BITS);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    logic [VALUE_BITS-1:0] quot_reg;
    logic [BASE_W-1:0]     rem_reg;
    logic [BASE_W-1:0]     dvs_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [BASE_W:0] shifted;
    logic [BASE_W:0] diff;
    logic            fits;

    assign shifted = {rem_reg, quot_reg[VALUE_BITS-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_ONE);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_FULL;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_ONE;
                if (cnt_reg == CNT_ONE) busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[VALUE_BITS-2:0], fits};
            rem_reg  <= fits ? diff[BASE_W-1:0] : shifted[BASE_W-1:0];
        end
    end

    assign quotient  = quot_reg;
    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/core/rbc_store.sv -----
// Digit store: remainders held until they are sent out in reverse order.
`default_nettype none

module rbc_store (
    input  wire logic                          aclk,
    input  wire logic                          wr_en,
    input  wire logic [rbc_pkg::STORE_AW-1:0]  wr_addr,
    input  wire logic [rbc_pkg::BASE_W-1:0]    wr_data,
    input  wire logic                          rd_en,
    input  wire logic [rbc_pkg::STORE_AW-1:0]  rd_addr,
    output logic [rbc_pkg::BASE_W-1:0]         rd_data
);
    import rbc_pkg::*;

    logic [BASE_W-1:0] mem [STORE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/radix_base_converter.sv -----
// Top level of the radix base converter: accumulator, sequencer and output register.
//
//  channel  | dir | word contents (lowest bit first)
//  s_axis   | in  | tdata: digit_char[7:0]; tlast: last_char
//  m_axis   | out | tdata: out_char[7:0]; tlast: last_out;
//           |     | tuser: empty_value, overflowed, bad_char
//  cfg      | in  | cfg_addr 0: in_base, 1: out_base; cfg_wdata[5:0]
//
// Each character is folded into the value with one multiply-accumulate in the idle state.
// The final character then runs the shared divider once per output digit, and each digit
// leaves the digit store in reverse order through a read state and an output state.
// The divider produces one quotient bit per cycle; s_axis is not ready meanwhile.
// Reset is synchronous on aresetn low; the digit store needs no clearing.
// A stall on m_axis holds the sequencer in its emit state until the word is taken.
`default_nettype none

module radix_base_converter #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,   // digit_char
    input  wire logic                          s_axis_tlast,   // last_char
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [7:0]                         m_axis_tdata,   // out_char
    output logic                               m_axis_tlast,   // last_out
    output logic [2:0]                         m_axis_tuser,   // empty_value, overflowed, bad_char
    input  wire logic                          cfg_wr_en,
    input  wire rbc_pkg::cfg_addr_t            cfg_addr,
    input  wire logic [rbc_pkg::BASE_W-1:0]    cfg_wdata
);
    import rbc_pkg::*;

    localparam int PW = VALUE_BITS + BASE_W;
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STORE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV_GO, S_DIV_WAIT, S_EMIT_RD, S_EMIT_OUT, S_EMIT_ZERO
    } state_t;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  ovf_reg, ovf_next;
    logic                  bad_reg, bad_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]     m_char_reg, m_char_next;
    logic                  m_last_reg, m_last_next;
    logic [FLAG_W-1:0]     m_user_reg, m_user_next;

    logic [BASE_W-1:0]     in_base_reg, out_base_reg;

    char_dec_t             dec;
    logic [PW-1:0]         prod;
    logic                  accept;
    logic                  slot_free;
    logic [CNT_W-1:0]      cnt_m1;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_quot;
    div_stat_t             div_stat;

    logic                  st_wr_en;
    logic                  st_rd_en;
    logic [BASE_W-1:0]     st_rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_base_reg  <= IN_BASE_RST;
            out_base_reg <= OUT_BASE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_IN_BASE:  in_base_reg  <= cfg_wdata;
                REG_OUT_BASE: out_base_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign dec       = decode_char(s_axis_tdata);
    assign prod      = PW'(acc_reg) * PW'(clamp_base(in_base_reg)) + PW'(dec.digit);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign slot_free = !m_valid_reg || m_axis_tready;
    assign cnt_m1    = cnt_reg - CNT_ONE;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign div_start     = (state_reg == S_DIV_GO) && (acc_reg != '0);
    assign st_wr_en      = (state_reg == S_DIV_WAIT) && div_stat.done && (cnt_reg < CNT_FULL);
    assign st_rd_en      = (state_reg == S_EMIT_RD);

    always_comb begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        ovf_next     = ovf_reg;
        bad_next     = bad_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    // Any bit above the value width means the sum wrapped.
                    acc_next = prod[VALUE_BITS-1:0];
                    ovf_next = ovf_reg || (prod[PW-1:VALUE_BITS] != '0);
                    bad_next = bad_reg || dec.bad;
                    cnt_next = '0;
                    if (s_axis_tlast) state_next = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                if (acc_reg == '0) state_next = S_EMIT_ZERO;
                else state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_stat.done) begin
                    acc_next = div_quot;
                    if (cnt_reg < CNT_FULL) cnt_next = cnt_reg + CNT_ONE;
                    else ovf_next = 1'b1;
                    if (div_quot == '0) state_next = S_EMIT_RD;
                    else state_next = S_DIV_GO;
                end
            end
            S_EMIT_RD: begin
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = encode_digit(st_rd_data);
                    m_last_next  = (cnt_reg == CNT_ONE);
                    m_user_next  = {bad_reg, ovf_reg, 1'b0};
                    cnt_next     = cnt_m1;
                    if (cnt_reg == CNT_ONE) begin
                        ovf_next   = 1'b0;
                        bad_next   = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_EMIT_ZERO: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = '0;
                    m_last_next  = 1'b1;
                    m_user_next  = {bad_reg, ovf_reg, 1'b1};
                    ovf_next     = 1'b0;
                    bad_next     = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            acc_reg     <= '0;
            ovf_reg     <= 1'b0;
            bad_reg     <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            ovf_reg     <= ovf_next;
            bad_reg     <= bad_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    rbc_div #(
        .VALUE_BITS(VALUE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (clamp_base(out_base_reg)),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    rbc_store u_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (cnt_reg[STORE_AW-1:0]),
        .wr_data (div_stat.rem),
        .rd_en   (st_rd_en),
        .rd_addr (cnt_m1[STORE_AW-1:0]),
        .rd_data (st_rd_data)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_char_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

    // A zero value is always sent as a single zero word that closes the run.
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("empty word without last or with nonzero data");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_FULL)
        else $error("digit count above store depth");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> state_reg == S_DIV_WAIT)
        else $error("divider finished outside the wait state");

    a_emit_has_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT_RD) |-> (cnt_reg != '0))
        else $error("emit started with no stored digit");

endmodule

`default_nettype wire
